// ----- design/bpk_pkg.sv -----
// shared types, constants and a helper function for the lsb-first bit packer
// no dependencies; used by the front end, queue, back end and core of the packer
package bpk_pkg;

   localparam int unsigned WORD_BITS     = 32;
   localparam int unsigned WIDTH_BITS    = 6;
   localparam int unsigned OFFSET_BITS   = 5;
   localparam int unsigned CAP_BITS      = 16;
   localparam int unsigned POINTER_BITS  = 11;
   localparam int unsigned DONE_IDX_BITS = 10;
   localparam logic [CAP_BITS-1:0] CAPACITY_RESET = 16'd32768;

   // classified push waiting in the queue
   typedef struct packed {
      logic [WORD_BITS-1:0]  value;     // already masked to width
      logic [WIDTH_BITS-1:0] width;
      logic                  width_ok;  // width in 1..32
   } item_type;

   typedef struct packed {
      logic                     accepted;
      logic                     word_done;
      logic [DONE_IDX_BITS-1:0] done_index;
      logic [WORD_BITS-1:0]     done_word;
      logic [POINTER_BITS-1:0]  open_index;
      logic [WORD_BITS-1:0]     open_word;
      logic [CAP_BITS-1:0]      bits_used;
   } result_type;

   // low n bits set, all ones for n of 32 or more
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [WIDTH_BITS-1:0] n);
      logic [WORD_BITS-1:0] m;
      if (n >= 6'd32) begin
         m = '1;
      end else begin
         m = ~({WORD_BITS{1'b1}} << n);
      end
      return m;
   endfunction

endpackage

// ----- design/bpk_front.sv -----
// front end of the packer: checks the push width and masks the value
// depends on bpk_pkg
module bpk_front (
   input  logic [31:0]        req_push_value,
   input  logic [5:0]         req_push_width,
   output bpk_pkg::item_type  item
);

   logic width_ok;

   assign width_ok = (req_push_width != 6'd0) && (req_push_width <= 6'd32);

   always_comb begin
      item.value    = req_push_value & bpk_pkg::low_mask(req_push_width);
      item.width    = req_push_width;
      item.width_ok = width_ok;
   end

endmodule

// ----- design/bpk_queue.sv -----
// two-entry queue between front and back end of the packer
// depends on bpk_pkg
module bpk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bpk_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output bpk_pkg::item_type head
);

   bpk_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- design/bpk_back.sv -----
// back end of the packer: capacity check, shift-and-or packing, result register
// depends on bpk_pkg
module bpk_back #(
   parameter int unsigned BUFFER_WORDS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          capacity,
   input  logic                 item_valid,
   input  bpk_pkg::item_type    item,
   output logic                 item_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bpk_pkg::result_type  result
);

   localparam int unsigned LIMIT_BITS = 22;
   localparam logic [LIMIT_BITS-1:0] BUF_BITS = LIMIT_BITS'(BUFFER_WORDS * 32);

   logic [31:0] partial_ff, partial_in;
   logic [4:0]  offset_ff, offset_in;
   logic [10:0] pointer_ff, pointer_in;
   logic [15:0] total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bpk_pkg::result_type result_ff, result_in;

   logic [LIMIT_BITS-1:0] cap_wide, limit;
   logic [16:0] sum;
   logic        fits;
   logic [63:0] acc;
   logic [5:0]  new_off;

   assign item_pop = item_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cap_wide = {6'd0, capacity};
      limit    = (BUF_BITS < cap_wide) ? BUF_BITS : cap_wide;
      sum      = {1'b0, total_ff} + {11'd0, item.width};
      fits     = item.width_ok && ({5'd0, sum} <= limit);
      acc      = {32'd0, partial_ff & bpk_pkg::low_mask({1'b0, offset_ff})}
               | ({32'd0, item.value} << offset_ff);
      new_off  = {1'b0, offset_ff} + item.width;

      partial_in = partial_ff;
      offset_in  = offset_ff;
      pointer_in = pointer_ff;
      total_in   = total_ff;

      result_in            = '0;
      if (fits) begin
         result_in.accepted = 1'b1;
         if (new_off[5]) begin
            // word complete, spill bits open the next one
            result_in.word_done  = 1'b1;
            result_in.done_index = pointer_ff[9:0];
            result_in.done_word  = acc[31:0];
            partial_in           = acc[63:32];
            pointer_in           = pointer_ff + 11'd1;
         end else begin
            partial_in = acc[31:0];
         end
         offset_in = new_off[4:0];
         total_in  = sum[15:0];
      end
      result_in.open_index = pointer_in;
      result_in.open_word  = partial_in;
      result_in.bits_used  = total_in;

      rsp_valid_in = rsp_valid_ff;
      if (item_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         offset_ff    <= '0;
         pointer_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            partial_ff <= partial_in;
            offset_ff  <= offset_in;
            pointer_ff <= pointer_in;
            total_ff   <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

// ----- design/lsb_first_bit_packer_core.sv -----
// a push taken into the queue is registered there, then packed by the back end into the result register
// throughput: one push per cycle while the result is not stalled; the back end packs one queued push per cycle
// rsp_stall backs up into the two-entry queue, which raises req_stall once full
// reset: synchronous, active high; clears the open word, offset, word index and
// bit total, empties the queue and sets capacity_bits to 32768
module lsb_first_bit_packer_core #(
   parameter int unsigned BUFFER_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,

   // push channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_push_value,
   input  logic [5:0]  req_push_width,

   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_word_done,
   output logic [9:0]  rsp_done_index,
   output logic [31:0] rsp_done_word,
   output logic [10:0] rsp_open_index,
   output logic [31:0] rsp_open_word,
   output logic [15:0] rsp_bits_used,

   // capacity register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_capacity_bits
);

   bpk_pkg::item_type   front_item;
   bpk_pkg::item_type   queue_head;
   bpk_pkg::result_type result;
   logic                queue_full;
   logic                queue_not_empty;
   logic                queue_push;
   logic                queue_pop;
   logic [15:0]         capacity_ff;

   // capacity register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bpk_pkg::CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_capacity_bits;
      end
   end

   // front end: width check and masking of the pushed value
   bpk_front u_front (
      .req_push_value (req_push_value),
      .req_push_width (req_push_width),
      .item           (front_item)
   );

   // stall only depends on queue occupancy
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   bpk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   // back end: packing state and registered result
   bpk_back #(
      .BUFFER_WORDS (BUFFER_WORDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .capacity   (capacity_ff),
      .item_valid (queue_not_empty),
      .item       (queue_head),
      .item_pop   (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result     (result)
   );

   // result fields out to ports
   assign rsp_accepted   = result.accepted;
   assign rsp_word_done  = result.word_done;
   assign rsp_done_index = result.done_index;
   assign rsp_done_word  = result.done_word;
   assign rsp_open_index = result.open_index;
   assign rsp_open_word  = result.open_word;
   assign rsp_bits_used  = result.bits_used;

endmodule

// ----- design/bpk_checker.sv -----
// port-level checks for the lsb-first bit packer and its bind
// depends only on the ports of lsb_first_bit_packer_core
module bpk_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_accepted,
   input logic        rsp_word_done,
   input logic [9:0]  rsp_done_index,
   input logic [31:0] rsp_done_word,
   input logic [10:0] rsp_open_index,
   input logic [31:0] rsp_open_word,
   input logic [15:0] rsp_bits_used
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_open_word)
         && $stable(rsp_bits_used) && $stable(rsp_done_word))
      else $error("stalled result changed");

   // rejected push reports no finished word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> !rsp_word_done && rsp_done_word == 32'd0
         && rsp_done_index == 10'd0)
      else $error("rejected push reports a word");

   // open word index follows the finished one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_done |-> rsp_open_index[9:0] == rsp_done_index + 10'd1)
      else $error("open index does not follow done index");

   // open word has no bits beyond the fill offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_open_word & ~((32'd1 << rsp_bits_used[4:0]) - 32'd1)) == 32'd0)
      else $error("open word has stray high bits");

endmodule

bind lsb_first_bit_packer_core bpk_checker u_bpk_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accepted   (rsp_accepted),
   .rsp_word_done  (rsp_word_done),
   .rsp_done_index (rsp_done_index),
   .rsp_done_word  (rsp_done_word),
   .rsp_open_index (rsp_open_index),
   .rsp_open_word  (rsp_open_word),
   .rsp_bits_used  (rsp_bits_used)
);
